// ===== src/tmg_pkg.sv =====
// ----------------------------------------------------------------------------
// tmg_pkg
// Shared types, constants and arithmetic helpers of the torus mesh generator.
// ----------------------------------------------------------------------------
package tmg_pkg;

   localparam int COUNT_BITS   = 8;
   localparam int CORDIC_STEPS = 14;
   localparam int TRIG_STAGES  = 8;   // seven rotation stages and one fold stage
   localparam int XY_W         = 19;  // CORDIC x and y datapath width
   localparam int Z_W          = 17;  // CORDIC residual angle width
   localparam int TRIG_W       = 18;  // cos and sin in Q1.16, clamped to +-1.0

   localparam logic signed [XY_W-1:0]   CORDIC_X0 = XY_W'(39797);
   localparam logic signed [TRIG_W-1:0] TRIG_LIM  = TRIG_W'(65536);

   // Rotation angles in units of 1/65536 of a turn.
   localparam logic signed [Z_W-1:0] TURN_ATAN [CORDIC_STEPS] = '{
      Z_W'(8192), Z_W'(4836), Z_W'(2555), Z_W'(1297), Z_W'(651), Z_W'(326),
      Z_W'(163), Z_W'(81), Z_W'(41), Z_W'(20), Z_W'(10), Z_W'(5), Z_W'(3), Z_W'(1)
   };

   // Command codes.
   localparam logic CMD_VERTEX = 1'b0;
   localparam logic CMD_QUAD   = 1'b1;

   // Configuration register indexes.
   localparam logic [7:0] REG_MAJOR_RADIUS = 8'd0;
   localparam logic [7:0] REG_MINOR_RADIUS = 8'd1;
   localparam logic [7:0] REG_RING_COUNT   = 8'd2;
   localparam logic [7:0] REG_SIDE_COUNT   = 8'd3;

   typedef struct packed {
      logic [COUNT_BITS-1:0] rem;
      logic [15:0]           quo;
   } div_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } cordic_type;

   // Four steps of restoring division of a fraction rem/count.
   function automatic div_type div_step4(input div_type d, input logic [COUNT_BITS-1:0] c);
      div_type                 o;
      logic [COUNT_BITS:0]     r2;
      o = d;
      for (int k = 0; k < 4; k++) begin
         r2 = {o.rem, 1'b0};
         if (r2 >= {1'b0, c}) begin
            r2    = r2 - {1'b0, c};
            o.quo = {o.quo[14:0], 1'b1};
         end else begin
            o.quo = {o.quo[14:0], 1'b0};
         end
         o.rem = r2[COUNT_BITS-1:0];
      end
      return o;
   endfunction

   // One CORDIC rotation step; the step number is always a constant.
   function automatic cordic_type cordic_iter(input cordic_type a, input int i);
      cordic_type             o;
      logic signed [XY_W-1:0] dx;
      logic signed [XY_W-1:0] dy;
      dx = a.y >>> i;
      dy = a.x >>> i;
      if (!a.z[Z_W-1]) begin
         o.x = a.x - dx;
         o.y = a.y + dy;
         o.z = a.z - TURN_ATAN[i];
      end else begin
         o.x = a.x + dx;
         o.y = a.y - dy;
         o.z = a.z + TURN_ATAN[i];
      end
      return o;
   endfunction

   function automatic logic signed [TRIG_W-1:0] clamp_trig(input logic signed [XY_W-1:0] v);
      logic signed [TRIG_W-1:0] o;
      if (v > XY_W'(TRIG_LIM)) begin
         o = TRIG_LIM;
      end else if (v < -XY_W'(TRIG_LIM)) begin
         o = -TRIG_LIM;
      end else begin
         o = v[TRIG_W-1:0];
      end
      return o;
   endfunction

endpackage

// ===== src/tmg_trig.sv =====
// ----------------------------------------------------------------------------
// tmg_trig
// Pipelined CORDIC cosine and sine of a phase given in 1/65536 of a turn.
// ----------------------------------------------------------------------------
module tmg_trig (
   input  logic                             clock,
   input  logic [tmg_pkg::TRIG_STAGES-1:0]  en,       // load enable of each stage
   input  logic [15:0]                      phase,
   output logic signed [tmg_pkg::TRIG_W-1:0] cos_out,
   output logic signed [tmg_pkg::TRIG_W-1:0] sin_out
);
   import tmg_pkg::*;

   localparam int ROT_STAGES = TRIG_STAGES - 1;

   cordic_type             rot_ff   [ROT_STAGES];
   cordic_type             rot_in   [ROT_STAGES];
   logic [1:0]             quad_ff  [ROT_STAGES];
   logic signed [TRIG_W-1:0] cos_ff, sin_ff;
   logic signed [TRIG_W-1:0] cos_in, sin_in;
   cordic_type             seed;

   // The residual angle within the quadrant is rotated two steps per stage.
   always_comb begin
      seed.x = CORDIC_X0;
      seed.y = '0;
      seed.z = Z_W'(phase[13:0]);
      rot_in[0] = cordic_iter(cordic_iter(seed, 0), 1);
      for (int k = 1; k < ROT_STAGES; k++) begin
         rot_in[k] = cordic_iter(cordic_iter(rot_ff[k-1], 2 * k), 2 * k + 1);
      end
   end

   // Fold the quadrant back in.
   always_comb begin
      unique case (quad_ff[ROT_STAGES-1])
         2'd0: begin
            cos_in = clamp_trig(rot_ff[ROT_STAGES-1].x);
            sin_in = clamp_trig(rot_ff[ROT_STAGES-1].y);
         end
         2'd1: begin
            cos_in = clamp_trig(-rot_ff[ROT_STAGES-1].y);
            sin_in = clamp_trig(rot_ff[ROT_STAGES-1].x);
         end
         2'd2: begin
            cos_in = clamp_trig(-rot_ff[ROT_STAGES-1].x);
            sin_in = clamp_trig(-rot_ff[ROT_STAGES-1].y);
         end
         default: begin
            cos_in = clamp_trig(rot_ff[ROT_STAGES-1].y);
            sin_in = clamp_trig(-rot_ff[ROT_STAGES-1].x);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         rot_ff[0]  <= rot_in[0];
         quad_ff[0] <= phase[15:14];
      end
      for (int k = 1; k < ROT_STAGES; k++) begin
         if (en[k]) begin
            rot_ff[k]  <= rot_in[k];
            quad_ff[k] <= quad_ff[k-1];
         end
      end
      if (en[TRIG_STAGES-1]) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

// ===== src/torus_mesh_generator_unit.sv =====
// ----------------------------------------------------------------------------
// torus_mesh_generator_unit
// Torus tessellation: vertex attributes or quad triangle indices per command.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake           Contents
//  req_     in         tvalid / tready     tdata: ring, side; tuser: command
//  rsp_     out        tvalid / tready     tdata: vertex or triangle; tlast
//  csr_     in         csr_valid/csr_ready register index and 16-bit data
//
// The pipeline is seventeen stages deep and takes one command per cycle
// unless stalled. A vertex command leaves one transfer; a quad command
// leaves two transfers and holds the output stage until its second beat
// is taken, which stalls the stages behind it. Each stage carries its own
// valid bit and loads when it is empty or the stage after it loads, so
// bubbles close up under a stall and nothing is lost or repeated. Reset is
// synchronous, clears the valid bits and the beat flag and loads defaults
// into the configuration registers; data registers are not reset.
//
// Stage map: stage 0 registers the command; stages 1 to 4 form the range
// checks, the quad indices and the two phase divisions (four quotient bits
// per stage); stages 5 to 12 are the CORDIC units; stage 13 holds the
// products with cos v and the minor radius; stage 14 the tube-point radius
// and rounded normal; stage 15 the position products and the signed normal;
// stage 16 is the output register.
module torus_mesh_generator_unit (
   input  logic         clock,
   input  logic         reset,
   // Command channel.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,   // ring_index [7:0], side_index [15:8]
   input  logic         req_tuser,   // cmd: 0 vertex, 1 quad
   // Result channel.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [191:0] rsp_tdata,   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                                     // tex_u, tex_v, tri_a, tri_b, tri_c, zero pad
   output logic         rsp_tlast,
   // Configuration write channel.
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_index,
   input  logic [15:0]  csr_data
);
   import tmg_pkg::*;

   localparam int NS  = 17;
   localparam int S_Q = 1;   // checks and quad indices
   localparam int S_P = 4;   // last division stage, phases ready
   localparam int S_T = 12;  // trig results ready
   localparam int S_M = 13;
   localparam int S_R = 14;
   localparam int S_N = 15;
   localparam int S_O = NS - 1;

   typedef struct packed {
      logic                     cmd;
      logic [7:0]               ring;
      logic [7:0]               side;
      logic                     vok;
      logic                     qok;
      logic                     ueq;
      logic [15:0]              ta;
      logic [15:0]              tb;
      logic [15:0]              tc;
      logic [15:0]              td;
      div_type                  du;
      div_type                  dv;
      logic [16:0]              pu;
      logic [15:0]              pv;
      logic signed [TRIG_W-1:0] cu;
      logic signed [TRIG_W-1:0] su;
      logic signed [TRIG_W-1:0] sv;
      logic signed [34:0]       mcv;
      logic signed [35:0]       ncx;
      logic signed [35:0]       ncy;
      logic signed [34:0]       mzs;
      logic signed [18:0]       r;
      logic signed [17:0]       nx;
      logic signed [17:0]       ny;
      logic signed [16:0]       nz;
      logic signed [19:0]       pz;
      logic signed [36:0]       pxr;
      logic signed [36:0]       pyr;
      logic signed [15:0]       fx;
      logic signed [15:0]       fy;
      logic signed [15:0]       fz;
   } st_type;

   st_type      st_ff [NS];
   st_type      st_in [NS];
   logic [NS-1:0] v_ff;
   logic [NS-1:0] ld;
   logic        beat_ff;
   logic        beat_last;

   logic [15:0] major_ff, minor_ff;
   logic [COUNT_BITS-1:0] ring_count_ff, side_count_ff;

   logic signed [TRIG_W-1:0] cu_w, su_w, cv_w, sv_w;

   logic [15:0] rs, ns;
   logic [7:0]  tn;
   logic [8:0]  side_p1;
   logic signed [34:0] mcv_rnd, mzs_rnd;
   logic signed [35:0] ncx_rnd, ncy_rnd;
   logic signed [18:0] sv_rnd;
   logic signed [36:0] px_rnd, py_rnd;
   logic signed [19:0] pos_x, pos_y;

   function automatic logic signed [15:0] norm_final(input logic signed [17:0] n,
                                                     input logic signed [18:0] r);
      logic signed [18:0] s;
      logic signed [15:0] o;
      if (r == '0) begin
         s = '0;
      end else if (r < 0) begin
         s = -{n[17], n};
      end else begin
         s = {n[17], n};
      end
      if (s > 19'sd16384) begin
         o = 16'sd16384;
      end else if (s < -19'sd16384) begin
         o = -16'sd16384;
      end else begin
         o = s[15:0];
      end
      return o;
   endfunction

   function automatic logic signed [19:0] sat20(input logic signed [20:0] v);
      logic signed [19:0] o;
      if (v > 21'sd524287) begin
         o = 20'sd524287;
      end else if (v < -21'sd524288) begin
         o = -20'sd524288;
      end else begin
         o = v[19:0];
      end
      return o;
   endfunction

   // ------------------------------------------------------------------
   // Configuration registers. Writes are always taken; unknown indexes
   // are dropped.
   // ------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         major_ff      <= 16'd4096;
         minor_ff      <= 16'd3072;
         ring_count_ff <= COUNT_BITS'(50);
         side_count_ff <= COUNT_BITS'(50);
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_MAJOR_RADIUS: major_ff      <= csr_data;
            REG_MINOR_RADIUS: minor_ff      <= csr_data;
            REG_RING_COUNT:   ring_count_ff <= csr_data[COUNT_BITS-1:0];
            REG_SIDE_COUNT:   side_count_ff <= csr_data[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Stall chain: a stage loads when it is empty or its successor loads.
   // The output stage moves on only after the last beat of its item.
   // ------------------------------------------------------------------
   assign beat_last = (st_ff[S_O].cmd == CMD_VERTEX) || beat_ff;

   always_comb begin
      ld[S_O] = !v_ff[S_O] || (rsp_tready && beat_last);
      for (int i = S_O - 1; i >= 0; i--) begin
         ld[i] = !v_ff[i] || ld[i+1];
      end
   end

   assign req_tready = ld[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff    <= '0;
         beat_ff <= 1'b0;
      end else begin
         if (ld[0]) begin
            v_ff[0] <= req_tvalid;
         end
         for (int i = 1; i < NS; i++) begin
            if (ld[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
         if (v_ff[S_O] && rsp_tready) begin
            beat_ff <= (st_ff[S_O].cmd == CMD_QUAD) && !beat_ff;
         end
      end
   end

   // ------------------------------------------------------------------
   // Cosine and sine of both angles; the results line up with stage 12.
   // ------------------------------------------------------------------
   tmg_trig u_trig_u (
      .clock   (clock),
      .en      (ld[S_T:S_P+1]),
      .phase   (st_ff[S_P].pu[15:0]),
      .cos_out (cu_w),
      .sin_out (su_w)
   );

   tmg_trig u_trig_v (
      .clock   (clock),
      .en      (ld[S_T:S_P+1]),
      .phase   (st_ff[S_P].pv),
      .cos_out (cv_w),
      .sin_out (sv_w)
   );

   // ------------------------------------------------------------------
   // Stage logic. Every stage passes its predecessor on and fills in the
   // fields that belong to it.
   // ------------------------------------------------------------------
   always_comb begin
      st_in[0]      = '0;
      st_in[0].cmd  = req_tuser;
      st_in[0].ring = req_tdata[7:0];
      st_in[0].side = req_tdata[15:8];
      for (int i = 1; i < NS; i++) begin
         st_in[i] = st_ff[i-1];
      end

      // Range checks, quad vertex indices and the first division steps.
      rs      = {8'd0, st_ff[0].ring} * {8'd0, side_count_ff};
      ns      = rs + {8'd0, side_count_ff};
      side_p1 = {1'b0, st_ff[0].side} + 9'd1;
      tn      = (side_p1 == {1'b0, side_count_ff}) ? 8'd0 : side_p1[7:0];
      st_in[S_Q].vok = (ring_count_ff != '0) && (side_count_ff != '0)
                       && (st_ff[0].ring <= ring_count_ff)
                       && (st_ff[0].side < side_count_ff);
      st_in[S_Q].qok = (st_ff[0].ring < ring_count_ff) && (st_ff[0].side < side_count_ff);
      st_in[S_Q].ueq = (st_ff[0].ring == ring_count_ff);
      st_in[S_Q].ta  = rs + {8'd0, st_ff[0].side};
      st_in[S_Q].tb  = ns + {8'd0, st_ff[0].side};
      st_in[S_Q].tc  = ns + {8'd0, tn};
      st_in[S_Q].td  = rs + {8'd0, tn};
      st_in[S_Q].du  = div_step4('{rem: st_ff[0].ring, quo: '0}, ring_count_ff);
      st_in[S_Q].dv  = div_step4('{rem: st_ff[0].side, quo: '0}, side_count_ff);
      for (int i = S_Q + 1; i <= S_P; i++) begin
         st_in[i].du = div_step4(st_ff[i-1].du, ring_count_ff);
         st_in[i].dv = div_step4(st_ff[i-1].dv, side_count_ff);
      end
      // A ring equal to the count is a full turn.
      st_in[S_P].pu = st_ff[S_P-1].ueq ? 17'h10000 : {1'b0, st_in[S_P].du.quo};
      st_in[S_P].pv = st_in[S_P].dv.quo;

      // Products with the trig results.
      st_in[S_M].cu  = cu_w;
      st_in[S_M].su  = su_w;
      st_in[S_M].sv  = sv_w;
      st_in[S_M].mcv = $signed({1'b0, minor_ff}) * cv_w;
      st_in[S_M].ncx = cv_w * cu_w;
      st_in[S_M].ncy = cv_w * su_w;
      st_in[S_M].mzs = $signed({1'b0, minor_ff}) * sv_w;

      // Radius to the tube point, rounded normal and z position.
      mcv_rnd = st_ff[S_M].mcv + 35'sd32768;
      mzs_rnd = st_ff[S_M].mzs + 35'sd32768;
      ncx_rnd = st_ff[S_M].ncx + 36'sd131072;
      ncy_rnd = st_ff[S_M].ncy + 36'sd131072;
      sv_rnd  = {st_ff[S_M].sv[TRIG_W-1], st_ff[S_M].sv} + 19'sd2;
      st_in[S_R].r  = $signed({3'd0, major_ff}) + mcv_rnd[34:16];
      st_in[S_R].nx = ncx_rnd[35:18];
      st_in[S_R].ny = ncy_rnd[35:18];
      st_in[S_R].nz = sv_rnd[18:2];
      st_in[S_R].pz = {mzs_rnd[34], mzs_rnd[34:16]};

      // Position products and the normal flipped by the sign of the radius.
      st_in[S_N].pxr = st_ff[S_R].r * st_ff[S_R].cu;
      st_in[S_N].pyr = st_ff[S_R].r * st_ff[S_R].su;
      st_in[S_N].fx  = norm_final(st_ff[S_R].nx, st_ff[S_R].r);
      st_in[S_N].fy  = norm_final(st_ff[S_R].ny, st_ff[S_R].r);
      st_in[S_N].fz  = norm_final({st_ff[S_R].nz[16], st_ff[S_R].nz}, st_ff[S_R].r);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NS; i++) begin
         if (ld[i]) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   // ------------------------------------------------------------------
   // Output stage: round and saturate the positions and pick the fields
   // of the current beat.
   // ------------------------------------------------------------------
   assign px_rnd = st_ff[S_O].pxr + 37'sd32768;
   assign py_rnd = st_ff[S_O].pyr + 37'sd32768;
   assign pos_x  = sat20(px_rnd[36:16]);
   assign pos_y  = sat20(py_rnd[36:16]);

   always_comb begin
      rsp_tdata = '0;
      if (st_ff[S_O].cmd == CMD_QUAD) begin
         if (st_ff[S_O].qok) begin
            rsp_tdata[156:141] = st_ff[S_O].ta;
            rsp_tdata[172:157] = beat_ff ? st_ff[S_O].tc : st_ff[S_O].tb;
            rsp_tdata[188:173] = beat_ff ? st_ff[S_O].td : st_ff[S_O].tc;
         end
      end else if (st_ff[S_O].vok) begin
         rsp_tdata[19:0]    = pos_x;
         rsp_tdata[39:20]   = pos_y;
         rsp_tdata[59:40]   = st_ff[S_O].pz;
         rsp_tdata[75:60]   = st_ff[S_O].fx;
         rsp_tdata[91:76]   = st_ff[S_O].fy;
         rsp_tdata[107:92]  = st_ff[S_O].fz;
         rsp_tdata[124:108] = st_ff[S_O].pu;
         rsp_tdata[140:125] = st_ff[S_O].pv;
      end
   end

   assign rsp_tvalid = v_ff[S_O];
   assign rsp_tlast  = beat_last;

endmodule
